@@ rtl/lru_key_value_cache_core_defines.svh @@
// Assertion macros used by the checker of the LRU key-value cache.
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LKVC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LKVC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/lkvc_pkg.sv @@
// Shared constants and types of the LRU key-value cache.
package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDXW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANKW   = IDXW;
    localparam int CNTW    = $clog2(ENTRIES + 1);
    localparam int CAPW    = 5;
    localparam int DATAW   = 32;
    localparam int CMPW    = (CAPW > CNTW) ? CAPW : CNTW;

    localparam logic [CAPW-1:0] CAP_RESET = CAPW'(16);

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_SET = 1'b1;

    localparam logic signed [DATAW-1:0] MISS_VALUE = '1;

    typedef struct packed {
        logic                    command;
        logic signed [DATAW-1:0] key;
        logic signed [DATAW-1:0] value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [DATAW-1:0] read_value;
    } t_rsp;

    // Outcome of one sweep of the comparator over all entries.
    typedef struct packed {
        logic            found;
        logic [IDXW-1:0] hit_idx;
        logic            free_found;
        logic [IDXW-1:0] free_idx;
        logic            victim_found;
        logic [IDXW-1:0] victim_idx;
    } t_scan;

endpackage

@@ rtl/lkvc_ram.sv @@
// Generic single-port-write, registered-read RAM used for keys and values.
module lkvc_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/lkvc_cmp.sv @@
// Shared comparator that checks one entry per cycle during a sweep.
module lkvc_cmp import lkvc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_en,
    input  logic [IDXW-1:0]         i_idx,
    input  logic signed [DATAW-1:0] i_entry_key,
    input  logic signed [DATAW-1:0] i_req_key,
    input  logic                    i_entry_valid,
    input  logic [RANKW-1:0]        i_entry_rank,
    input  logic [RANKW-1:0]        i_last_rank,
    output t_scan                   o_scan
);

    t_scan r_scan;

    // The first matching entry, the first free slot and the oldest entry are kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_scan <= '0;
        end else if (i_en) begin
            if (i_entry_valid && (i_entry_key == i_req_key) && !r_scan.found) begin
                r_scan.found   <= 1'b1;
                r_scan.hit_idx <= i_idx;
            end
            if (!i_entry_valid && !r_scan.free_found) begin
                r_scan.free_found <= 1'b1;
                r_scan.free_idx   <= i_idx;
            end
            if (i_entry_valid && (i_entry_rank == i_last_rank) && !r_scan.victim_found) begin
                r_scan.victim_found <= 1'b1;
                r_scan.victim_idx   <= i_idx;
            end
        end
    end

    assign o_scan = r_scan;

endmodule

@@ rtl/lru_key_value_cache_core.sv @@
// Top level of the fully associative key-value cache with LRU replacement.
//
// A request (get or set) is taken when start is high while busy is low. The
// block then sweeps its ENTRIES slots with a single key comparator, one slot
// per cycle through the registered read port of the key memory, and a get
// that hits then reads its value from the value memory. A get gives exactly
// one result, shown for a single cycle with o_strobe rising as busy falls;
// a set gives none. There is no way to hold a result off, so the receiver
// must take it when the strobe is high. A miss returns hit clear and a read
// value of all ones. The capacity register may be written at any time the
// block is idle; zero acts as one, and values above ENTRIES act as ENTRIES.
// Lowering it below the current occupancy drops nothing at once: each later
// insert replaces the oldest entry instead of adding one. Reset empties the
// cache immediately through per-slot valid bits.
module lru_key_value_cache_core import lkvc_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    input  t_req            i_req,
    output logic            busy,
    output logic            o_strobe,
    output t_rsp            o_rsp,
    input  logic            i_cfg_we,
    input  logic [CAPW-1:0] i_cfg_wdata
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;
    localparam logic [1:0] S_RESP   = 2'd3;

    logic [1:0]       r_state,   n_state;
    t_req             r_req,     n_req;
    logic [CNTW-1:0]  r_idx,     n_idx;
    logic             r_cmp_en,  n_cmp_en;
    logic [IDXW-1:0]  r_cmp_idx, n_cmp_idx;
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [RANKW-1:0] r_rank [ENTRIES];
    logic [RANKW-1:0] n_rank [ENTRIES];
    logic [CNTW-1:0]  r_occ,     n_occ;
    logic [CAPW-1:0]  r_cap,     n_cap;
    logic             r_out_vld, n_out_vld;
    t_rsp             r_out,     n_out;

    logic             w_issue;
    logic             w_clear;
    logic [CMPW-1:0]  w_cap_ext;
    logic [CMPW-1:0]  w_eff_cap;
    logic             w_full;
    logic [CNTW-1:0]  w_occ_m1;
    logic [RANKW-1:0] w_last_rank;
    logic [IDXW-1:0]  w_ins_slot;
    logic [RANKW-1:0] w_hit_rank;
    t_scan            w_scan;
    logic [DATAW-1:0] w_key_rdata;
    logic [DATAW-1:0] w_val_rdata;
    logic             w_key_we;
    logic             w_val_we;
    logic [IDXW-1:0]  w_val_waddr;

    // The effective capacity clamps the register into the range 1 .. ENTRIES.
    assign w_cap_ext = CMPW'(r_cap);
    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = CMPW'(1);
        end else if (w_cap_ext > CMPW'(ENTRIES)) begin
            w_eff_cap = CMPW'(ENTRIES);
        end else begin
            w_eff_cap = w_cap_ext;
        end
    end
    assign w_full = (CMPW'(r_occ) >= w_eff_cap);

    // Valid ranks always run from zero to occupancy minus one, so the oldest
    // entry is the one whose rank equals occupancy minus one.
    assign w_occ_m1    = r_occ - CNTW'(1);
    assign w_last_rank = w_occ_m1[RANKW-1:0];

    // A key is read in every sweep cycle until every slot has been issued.
    assign w_issue = (r_state == S_SCAN) && (r_idx < CNTW'(ENTRIES));
    assign w_clear = (r_state == S_IDLE) && start;

    // A new key replaces the oldest entry when full, else fills the first free slot.
    assign w_ins_slot = w_full ? w_scan.victim_idx : w_scan.free_idx;
    assign w_hit_rank = r_rank[w_scan.hit_idx];

    assign w_key_we    = (r_state == S_DECIDE) && (r_req.command == CMD_SET) && !w_scan.found;
    assign w_val_we    = (r_state == S_DECIDE) && (r_req.command == CMD_SET);
    assign w_val_waddr = w_scan.found ? w_scan.hit_idx : w_ins_slot;

    lkvc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (DATAW)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (w_ins_slot),
        .i_wdata (r_req.key),
        .i_re    (w_issue),
        .i_raddr (r_idx[IDXW-1:0]),
        .o_rdata (w_key_rdata)
    );

    lkvc_ram #(
        .DEPTH (ENTRIES),
        .WIDTH (DATAW)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (w_val_waddr),
        .i_wdata (r_req.value),
        .i_re    (r_state == S_DECIDE),
        .i_raddr (w_scan.hit_idx),
        .o_rdata (w_val_rdata)
    );

    // The comparator works on each key in the cycle after it is read, matching the registered read port.
    lkvc_cmp u_cmp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (w_clear),
        .i_en          (r_cmp_en),
        .i_idx         (r_cmp_idx),
        .i_entry_key   (w_key_rdata),
        .i_req_key     (r_req.key),
        .i_entry_valid (r_valid[r_cmp_idx]),
        .i_entry_rank  (r_rank[r_cmp_idx]),
        .i_last_rank   (w_last_rank),
        .o_scan        (w_scan)
    );

    always_comb begin
        n_state   = r_state;
        n_req     = r_req;
        n_idx     = r_idx;
        n_cmp_en  = 1'b0;
        n_cmp_idx = r_cmp_idx;
        n_valid   = r_valid;
        n_rank    = r_rank;
        n_occ     = r_occ;
        n_cap     = i_cfg_we ? i_cfg_wdata : r_cap;
        n_out_vld = 1'b0;
        n_out     = r_out;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_idx   = '0;
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                if (w_issue) begin
                    n_idx     = r_idx + CNTW'(1);
                    n_cmp_en  = 1'b1;
                    n_cmp_idx = r_idx[IDXW-1:0];
                end
                if (r_cmp_en && (r_cmp_idx == IDXW'(ENTRIES - 1))) begin
                    n_state = S_DECIDE;
                end
            end

            S_DECIDE: begin
                if (w_scan.found) begin
                    // Every entry more recent than the hit ages by one.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (r_valid[i] && (r_rank[i] < w_hit_rank)) begin
                            n_rank[i] = r_rank[i] + RANKW'(1);
                        end
                    end
                    n_rank[w_scan.hit_idx] = '0;
                    n_state = (r_req.command == CMD_GET) ? S_RESP : S_IDLE;
                end else if (r_req.command == CMD_GET) begin
                    n_out_vld        = 1'b1;
                    n_out.hit        = 1'b0;
                    n_out.read_value = MISS_VALUE;
                    n_state          = S_IDLE;
                end else begin
                    // Insert: all other valid entries age, the new one is newest.
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (IDXW'(i) == w_ins_slot) begin
                            n_valid[i] = 1'b1;
                            n_rank[i]  = '0;
                        end else if (r_valid[i]) begin
                            n_rank[i] = r_rank[i] + RANKW'(1);
                        end
                    end
                    if (!w_full) begin
                        n_occ = r_occ + CNTW'(1);
                    end
                    n_state = S_IDLE;
                end
            end

            S_RESP: begin
                n_out_vld        = 1'b1;
                n_out.hit        = 1'b1;
                n_out.read_value = w_val_rdata;
                n_state          = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_cmp_en  <= 1'b0;
            r_valid   <= '0;
            r_occ     <= '0;
            r_cap     <= CAP_RESET;
            r_out_vld <= 1'b0;
            for (int i = 0; i < ENTRIES; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_cmp_en  <= n_cmp_en;
            r_valid   <= n_valid;
            r_occ     <= n_occ;
            r_cap     <= n_cap;
            r_out_vld <= n_out_vld;
            r_rank    <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_cmp_idx <= n_cmp_idx;
        r_out     <= n_out;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_out_vld;
    assign o_rsp    = r_out;

endmodule

@@ rtl/lkvc_checker.sv @@
// Port-level checker for the LRU key-value cache, bound to the top level.
`include "lru_key_value_cache_core_defines.svh"

module lkvc_checker import lkvc_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_strobe,
    input t_rsp o_rsp
);

    `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted request did not raise busy")
    `LKVC_ASSERT_NEXT(a_no_early_result, start && !busy, !o_strobe, "result too soon after request")
    `LKVC_ASSERT_SAME(a_result_idle, o_strobe, !busy, "result shown while busy")
    `LKVC_ASSERT_NEXT(a_single_strobe, o_strobe, !o_strobe, "result strobe longer than one cycle")
    `LKVC_ASSERT_SAME(a_miss_value, o_strobe && !o_rsp.hit, o_rsp.read_value == MISS_VALUE, "miss value is not all ones")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (.*);
